// ===== src/jrdz_pkg.sv =====
// Shared types and constants for the joystick radial dead-zone block.
// No dependencies; every other file of the block takes names from here by scope.
`timescale 1ns / 1ps

package jrdz_pkg;

  // Register file geometry
  localparam int CFG_IDX_W = 4;
  localparam int REG_W     = 16;

  // Result format: Q1.15 signed
  localparam int OUT_W  = 16;
  localparam int FRAC_W = 15;

  localparam logic [REG_W-1:0] ONE_Q15 = 16'h8000;
  localparam logic [OUT_W-1:0] OUT_MAX = 16'h7fff;

  // Register reset values
  localparam logic [REG_W-1:0] DEAD_ZONE_RST  = 16'd8000;
  localparam logic [REG_W-1:0] FULL_SCALE_RST = 16'd30000;

  // Iterations of the digit-recurrence units done between two registers
  localparam int STEPS_PER_STAGE = 4;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEAD_ZONE  = 4'd0,
    REG_FULL_SCALE = 4'd1
  } cfg_reg_t;

endpackage

// ===== src/jrdz_isqrt.sv =====
// Pipelined integer square root (floor), digit by digit, a few digits per stage.
// Uses jrdz_pkg for the number of digits per stage; carries a sideband word alongside.
`timescale 1ns / 1ps

module jrdz_isqrt #(
  parameter int RW = 16,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            vld_i,
  input  logic [2*RW-1:0] n_i,
  input  logic [SW-1:0]   side_i,
  output logic            vld_o,
  output logic [RW-1:0]   root_o,
  output logic [SW-1:0]   side_o
);

  localparam int SPS  = jrdz_pkg::STEPS_PER_STAGE;
  localparam int NSTG = (RW + SPS - 1) / SPS;

  logic            vld_r  [NSTG];
  logic [RW:0]     rem_r  [NSTG];
  logic [2*RW-1:0] lo_r   [NSTG];
  logic [RW-1:0]   root_r [NSTG];
  logic [SW-1:0]   side_r [NSTG];

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    logic            vld_in;
    logic [RW:0]     rem_in;
    logic [2*RW-1:0] lo_in;
    logic [RW-1:0]   root_in;
    logic [SW-1:0]   side_in;
    logic [RW:0]     rem_nxt;
    logic [2*RW-1:0] lo_nxt;
    logic [RW-1:0]   root_nxt;

    if (s == 0) begin : g_head
      assign vld_in  = vld_i;
      assign rem_in  = '0;
      assign lo_in   = n_i;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_body
      assign vld_in  = vld_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign lo_in   = lo_r[s-1];
      assign root_in = root_r[s-1];
      assign side_in = side_r[s-1];
    end

    // Bring down two bits, try root*4+1, keep the root bit if it fits
    always_comb begin
      logic [RW+2:0] rem2;
      logic [RW+2:0] trial;
      logic [RW+2:0] dif;
      rem2     = '0;
      trial    = '0;
      dif      = '0;
      rem_nxt  = rem_in;
      lo_nxt   = lo_in;
      root_nxt = root_in;
      for (int k = 0; k < SPS; k++) begin
        if (s * SPS + k < RW) begin
          rem2   = {rem_nxt, lo_nxt[2*RW-1 -: 2]};
          trial  = {1'b0, root_nxt, 2'b01};
          lo_nxt = lo_nxt << 2;
          if (rem2 >= trial) begin
            dif      = rem2 - trial;
            rem_nxt  = dif[RW:0];
            root_nxt = {root_nxt[RW-2:0], 1'b1};
          end else begin
            rem_nxt  = rem2[RW:0];
            root_nxt = {root_nxt[RW-2:0], 1'b0};
          end
        end
      end
    end

    // Advance the valid bit with the stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_in;
      end
    end

    // Advance the payload
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= rem_nxt;
        lo_r[s]   <= lo_nxt;
        root_r[s] <= root_nxt;
        side_r[s] <= side_in;
      end
    end
  end

  assign vld_o  = vld_r[NSTG-1];
  assign root_o = root_r[NSTG-1];
  assign side_o = side_r[NSTG-1];

endmodule

// ===== src/jrdz_div.sv =====
// Pipelined restoring divider: quotient bits are produced a few per stage.
// Expects a starting remainder below the divisor. Uses jrdz_pkg for the stage size.
`timescale 1ns / 1ps

module jrdz_div #(
  parameter int DW = 16,
  parameter int QW = 16,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_i,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] lo_i,
  input  logic [DW-1:0] dvsr_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [QW-1:0] quot_o,
  output logic [SW-1:0] side_o
);

  localparam int SPS  = jrdz_pkg::STEPS_PER_STAGE;
  localparam int NSTG = (QW + SPS - 1) / SPS;

  logic          vld_r  [NSTG];
  logic [DW-1:0] rem_r  [NSTG];
  logic [QW-1:0] lo_r   [NSTG];
  logic [QW-1:0] quot_r [NSTG];
  logic [DW-1:0] dvsr_r [NSTG];
  logic [SW-1:0] side_r [NSTG];

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    logic          vld_in;
    logic [DW-1:0] rem_in;
    logic [QW-1:0] lo_in;
    logic [QW-1:0] quot_in;
    logic [DW-1:0] dvsr_in;
    logic [SW-1:0] side_in;
    logic [DW-1:0] rem_nxt;
    logic [QW-1:0] lo_nxt;
    logic [QW-1:0] quot_nxt;

    if (s == 0) begin : g_head
      assign vld_in  = vld_i;
      assign rem_in  = rem_i;
      assign lo_in   = lo_i;
      assign quot_in = '0;
      assign dvsr_in = dvsr_i;
      assign side_in = side_i;
    end else begin : g_body
      assign vld_in  = vld_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign lo_in   = lo_r[s-1];
      assign quot_in = quot_r[s-1];
      assign dvsr_in = dvsr_r[s-1];
      assign side_in = side_r[s-1];
    end

    // Shift in the next dividend bit, subtract the divisor where it fits
    always_comb begin
      logic [DW:0] trial;
      logic [DW:0] dif;
      trial    = '0;
      dif      = '0;
      rem_nxt  = rem_in;
      lo_nxt   = lo_in;
      quot_nxt = quot_in;
      for (int k = 0; k < SPS; k++) begin
        if (s * SPS + k < QW) begin
          trial  = {rem_nxt, lo_nxt[QW-1]};
          lo_nxt = lo_nxt << 1;
          if (trial >= {1'b0, dvsr_in}) begin
            dif      = trial - {1'b0, dvsr_in};
            rem_nxt  = dif[DW-1:0];
            quot_nxt = {quot_nxt[QW-2:0], 1'b1};
          end else begin
            rem_nxt  = trial[DW-1:0];
            quot_nxt = {quot_nxt[QW-2:0], 1'b0};
          end
        end
      end
    end

    // Advance the valid bit with the stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_in;
      end
    end

    // Advance the payload
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= rem_nxt;
        lo_r[s]   <= lo_nxt;
        quot_r[s] <= quot_nxt;
        dvsr_r[s] <= dvsr_in;
        side_r[s] <= side_in;
      end
    end
  end

  assign vld_o  = vld_r[NSTG-1];
  assign quot_o = quot_r[NSTG-1];
  assign side_o = side_r[NSTG-1];

endmodule

// ===== src/joystick_radial_dead_zone.sv =====
// Top level of the joystick radial dead-zone conditioner.
// Depends on jrdz_pkg, jrdz_isqrt and jrdz_div.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid / in_stall): one signed stick sample per request,
//   in_x_in and in_y_in, AXIS_WIDTH bits each.
//   Result channel (out_valid / out_stall): one Q1.15 direction per request,
//   out_x_out and out_y_out, scaled by where the sample radius falls between
//   the dead-zone circle and the full-scale circle.
//   Config channel (cfg_valid / cfg_ready): index 0 writes the dead zone,
//   index 1 the full scale; other indexes are dropped. Write only while idle.
// Timing
//   The pipeline has 14 + ceil(AXIS_WIDTH/4) register stages, 18 at
//   AXIS_WIDTH 16. One request enters per cycle while in_stall is low. The
//   stage count is set by the square-root pipeline (one root bit per step)
//   and the gain and axis dividers (one quotient bit per step), four steps
//   between registers.
// Reset and stall
//   rst_n clears every valid bit and loads the dead zone (8000) and full scale
//   (30000). A stalled result holds the whole pipeline in place; in_stall then
//   rises in the same cycle. cfg_ready is always high.
module joystick_radial_dead_zone #(
  parameter int AXIS_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [AXIS_WIDTH-1:0]         in_x_in,
  input  logic signed [AXIS_WIDTH-1:0]         in_y_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [jrdz_pkg::OUT_W-1:0]    out_x_out,
  output logic signed [jrdz_pkg::OUT_W-1:0]    out_y_out,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [jrdz_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [jrdz_pkg::REG_W-1:0]     cfg_data
);

  localparam int A      = AXIS_WIDTH;
  localparam int SQ_W   = 2 * A;
  localparam int REG_W  = jrdz_pkg::REG_W;
  localparam int OUT_W  = jrdz_pkg::OUT_W;
  localparam int FRAC_W = jrdz_pkg::FRAC_W;
  localparam int CW     = ((A > REG_W) ? A : REG_W) + 1;
  localparam int MX_W   = A + REG_W;
  localparam int SQ_SW  = 2 * A + 2;
  localparam int FD_SW  = 3 * A + 4;

  logic en;

  // Configuration registers
  logic [REG_W-1:0] dead_zone_r;
  logic [REG_W-1:0] full_scale_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dead_zone_r  <= jrdz_pkg::DEAD_ZONE_RST;
      full_scale_r <= jrdz_pkg::FULL_SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        jrdz_pkg::REG_DEAD_ZONE:  dead_zone_r  <= cfg_data;
        jrdz_pkg::REG_FULL_SCALE: full_scale_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold everything while a finished result is stalled
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // Stage 1: sign and magnitude of each axis
  logic         v1_r, sx1_r, sy1_r;
  logic [A-1:0] ax1_r, ay1_r;
  logic [A-1:0] ax_nxt, ay_nxt;

  assign ax_nxt = in_x_in[A-1] ? (~in_x_in + A'(1)) : in_x_in;
  assign ay_nxt = in_y_in[A-1] ? (~in_y_in + A'(1)) : in_y_in;

  // Stage 2: squares
  logic            v2_r, sx2_r, sy2_r;
  logic [A-1:0]    ax2_r, ay2_r;
  logic [SQ_W-1:0] xx2_r, yy2_r;

  // Stage 3: squared radius
  logic            v3_r, sx3_r, sy3_r;
  logic [A-1:0]    ax3_r, ay3_r;
  logic [SQ_W-1:0] sum3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx1_r  <= in_x_in[A-1];
      sy1_r  <= in_y_in[A-1];
      ax1_r  <= ax_nxt;
      ay1_r  <= ay_nxt;
      sx2_r  <= sx1_r;
      sy2_r  <= sy1_r;
      ax2_r  <= ax1_r;
      ay2_r  <= ay1_r;
      xx2_r  <= SQ_W'(ax1_r) * SQ_W'(ax1_r);
      yy2_r  <= SQ_W'(ay1_r) * SQ_W'(ay1_r);
      sx3_r  <= sx2_r;
      sy3_r  <= sy2_r;
      ax3_r  <= ax2_r;
      ay3_r  <= ay2_r;
      sum3_r <= xx2_r + yy2_r;
    end
  end

  // Radius
  logic             sq_vld;
  logic [A-1:0]     sq_len;
  logic [SQ_SW-1:0] sq_side;

  jrdz_isqrt #(
    .RW (A),
    .SW (SQ_SW)
  ) u_isqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (v3_r),
    .n_i    (sum3_r),
    .side_i ({sx3_r, sy3_r, ax3_r, ay3_r}),
    .vld_o  (sq_vld),
    .root_o (sq_len),
    .side_o (sq_side)
  );

  // Stage 4: dead-zone test and set-up of the gain division
  logic [CW-1:0] len_e, dz_e, fs_e, diff, span;
  logic          zero_nxt, satf_nxt;

  assign len_e    = CW'(sq_len);
  assign dz_e     = CW'(dead_zone_r);
  assign fs_e     = CW'(full_scale_r);
  assign diff     = len_e - dz_e;
  assign span     = fs_e - dz_e;
  assign zero_nxt = (sq_len == '0) || (len_e < dz_e);
  assign satf_nxt = (fs_e <= dz_e) || (diff >= span);

  logic             v4_r, zero4_r, satf4_r;
  logic [REG_W-1:0] rem4_r, span4_r;
  logic [SQ_SW-1:0] side4_r;
  logic [A-1:0]     len4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero4_r <= zero_nxt;
      satf4_r <= satf_nxt;
      rem4_r  <= diff[REG_W-1:0];
      span4_r <= span[REG_W-1:0];
      side4_r <= sq_side;
      len4_r  <= sq_len;
    end
  end

  // Gain: (length - dead zone) * 2^15 / (full scale - dead zone)
  logic              fd_vld;
  logic [FRAC_W-1:0] fd_quot;
  logic [FD_SW-1:0]  fd_side;

  jrdz_div #(
    .DW (REG_W),
    .QW (FRAC_W),
    .SW (FD_SW)
  ) u_gain_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (v4_r),
    .rem_i  (rem4_r),
    .lo_i   ('0),
    .dvsr_i (span4_r),
    .side_i ({zero4_r, satf4_r, side4_r, len4_r}),
    .vld_o  (fd_vld),
    .quot_o (fd_quot),
    .side_o (fd_side)
  );

  // Stage 5: clamp the gain and scale each axis magnitude
  logic             fd_zero, fd_satf, fd_sx, fd_sy;
  logic [A-1:0]     fd_ax, fd_ay, fd_len;
  logic [REG_W-1:0] gain;

  assign {fd_zero, fd_satf, fd_sx, fd_sy, fd_ax, fd_ay, fd_len} = fd_side;
  assign gain = fd_satf ? jrdz_pkg::ONE_Q15 : {1'b0, fd_quot};

  logic            v5_r, zero5_r, sx5_r, sy5_r;
  logic [MX_W-1:0] mx5_r, my5_r;
  logic [A-1:0]    len5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= fd_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero5_r <= fd_zero;
      sx5_r   <= fd_sx;
      sy5_r   <= fd_sy;
      len5_r  <= fd_len;
      mx5_r   <= MX_W'(fd_ax) * MX_W'(gain);
      my5_r   <= MX_W'(fd_ay) * MX_W'(gain);
    end
  end

  // Axis division by the radius; the quotient never exceeds the gain
  logic             dx_vld, dy_vld;
  logic [OUT_W-1:0] qx, qy;
  logic [1:0]       dx_side;
  logic             dy_side;

  jrdz_div #(
    .DW (A),
    .QW (OUT_W),
    .SW (2)
  ) u_x_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (v5_r),
    .rem_i  (mx5_r[MX_W-1 -: A]),
    .lo_i   (mx5_r[OUT_W-1:0]),
    .dvsr_i (len5_r),
    .side_i ({zero5_r, sx5_r}),
    .vld_o  (dx_vld),
    .quot_o (qx),
    .side_o (dx_side)
  );

  jrdz_div #(
    .DW (A),
    .QW (OUT_W),
    .SW (1)
  ) u_y_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (v5_r),
    .rem_i  (my5_r[MX_W-1 -: A]),
    .lo_i   (my5_r[OUT_W-1:0]),
    .dvsr_i (len5_r),
    .side_i (sy5_r),
    .vld_o  (dy_vld),
    .quot_o (qy),
    .side_o (dy_side)
  );

  // Output stage: restore sign, saturate +1.0, zero inside the dead zone
  logic             out_valid_r;
  logic [OUT_W-1:0] out_x_r, out_y_r;
  logic [OUT_W-1:0] x_nxt, y_nxt;

  always_comb begin
    if (dx_side[1]) begin
      x_nxt = '0;
      y_nxt = '0;
    end else begin
      if (dx_side[0]) begin
        x_nxt = ~qx + OUT_W'(1);
      end else begin
        x_nxt = (qx > jrdz_pkg::OUT_MAX) ? jrdz_pkg::OUT_MAX : qx;
      end
      if (dy_side) begin
        y_nxt = ~qy + OUT_W'(1);
      end else begin
        y_nxt = (qy > jrdz_pkg::OUT_MAX) ? jrdz_pkg::OUT_MAX : qy;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dx_vld && dy_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x_r <= x_nxt;
      out_y_r <= y_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_x_out = out_x_r;
  assign out_y_out = out_y_r;

endmodule

// ===== src/jrdz_chk.sv =====
// Port-level checker for the joystick radial dead-zone block, bound to the top level.
// Depends on jrdz_pkg for port widths.
`timescale 1ns / 1ps

module jrdz_chk #(
  parameter int AXIS_WIDTH = 16
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic signed [AXIS_WIDTH-1:0]         in_x_in,
  input logic signed [AXIS_WIDTH-1:0]         in_y_in,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [jrdz_pkg::OUT_W-1:0]    out_x_out,
  input logic signed [jrdz_pkg::OUT_W-1:0]    out_y_out,
  input logic                                 cfg_valid,
  input logic                                 cfg_ready,
  input logic        [jrdz_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic        [jrdz_pkg::REG_W-1:0]     cfg_data
);

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_x_out) && $stable(out_y_out))
    else $error("stalled result changed or dropped");

  // The input side only stalls behind a stalled result
  a_in_stall_cause: assert property (@(posedge clk)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind joystick_radial_dead_zone jrdz_chk #(.AXIS_WIDTH(AXIS_WIDTH)) u_jrdz_chk (.*);
